@@ hdl/elevator_stop_scheduler_macros.svh @@
// Assertion macros for the elevator stop scheduler.
// Relies on signals named clock and reset in the module that includes it.
`ifndef ELEVATOR_STOP_SCHEDULER_MACROS_SVH
`define ELEVATOR_STOP_SCHEDULER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ESS_CHECK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ESS_NEVER(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

@@ hdl/ess_pkg.sv @@
// Shared types and constants for the elevator stop scheduler.
// No dependencies; used by ess_scan and elevator_stop_scheduler.
`timescale 1ns / 1ps

package ess_pkg;

   // Floor number width on the ports (1-based floor numbers).
   localparam int FLOOR_W = 5;

   // Event codes.
   localparam logic [1:0] OP_CALL   = 2'd0;
   localparam logic [1:0] OP_ARRIVE = 2'd1;
   localparam logic [1:0] OP_PASS   = 2'd2;

   typedef enum logic [1:0] {
      DIR_STAY = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   // Scan request: direction, whether to start at the end of the floor range
   // (bottom when scanning up, top when scanning down), and a start floor.
   typedef struct packed {
      logic               up;
      logic               from_edge;
      logic [FLOOR_W-1:0] start;
   } scan_req_type;

   // Scan result: one-cycle done strobe, hit flag and the floor hit.
   typedef struct packed {
      logic               done;
      logic               found;
      logic [FLOOR_W-1:0] floor_num;
   } scan_res_type;

endpackage

@@ hdl/ess_scan.sv @@
// Serial search over the pending-call bits, one floor per cycle.
// Depends on ess_pkg for the request and result structs.
`timescale 1ns / 1ps

module ess_scan #(
   parameter int FLOOR_COUNT = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  ess_pkg::scan_req_type  req,
   input  logic [FLOOR_COUNT-1:0] pending,
   output ess_pkg::scan_res_type  res
);
   import ess_pkg::*;

   localparam int IDX_W  = $clog2(FLOOR_COUNT);
   localparam int SCAN_W = $clog2(FLOOR_COUNT + 2);
   localparam logic [SCAN_W-1:0] TOP_FLOOR    = SCAN_W'(FLOOR_COUNT);
   localparam logic [SCAN_W-1:0] BOTTOM_FLOOR = SCAN_W'(1);

   logic [SCAN_W-1:0] floor_ff;
   logic [SCAN_W-1:0] floor_idx;
   logic              up_ff;
   logic              active_ff;
   logic              done_ff;
   logic              found_ff;
   logic              hit;
   logic              at_end;

   always_comb begin
      floor_idx = floor_ff - BOTTOM_FLOOR;
      hit       = pending[floor_idx[IDX_W-1:0]];
      at_end    = up_ff ? (floor_ff >= TOP_FLOOR) : (floor_ff <= BOTTOM_FLOOR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         // Pulse done for one cycle when the walk stops on a hit or at the end.
         done_ff <= !start && active_ff && (hit || at_end);
         if (start) begin
            up_ff     <= req.up;
            active_ff <= 1'b1;
            if (req.from_edge) begin
               floor_ff <= req.up ? BOTTOM_FLOOR : TOP_FLOOR;
            end else begin
               floor_ff <= SCAN_W'(req.start);
            end
         end else if (active_ff) begin
            if (hit) begin
               active_ff <= 1'b0;
               found_ff  <= 1'b1;
            end else if (at_end) begin
               active_ff <= 1'b0;
               found_ff  <= 1'b0;
            end else if (up_ff) begin
               floor_ff <= floor_ff + BOTTOM_FLOOR;
            end else begin
               floor_ff <= floor_ff - BOTTOM_FLOOR;
            end
         end
      end
   end

   assign res.done      = done_ff;
   assign res.found     = found_ff;
   assign res.floor_num = FLOOR_W'(floor_ff);

endmodule

@@ hdl/elevator_stop_scheduler.sv @@
// Top level of the elevator stop scheduler: event decode, state and result register.
// Depends on ess_pkg, ess_scan and elevator_stop_scheduler_macros.svh.
`timescale 1ns / 1ps
`include "elevator_stop_scheduler_macros.svh"

// Usage
// Input channel req_*: one floor event per transfer (req_op: call, arrival,
// passed floor; req_floor: 1-based floor). A transfer happens on a rising edge
// with req_valid high and req_stall low.
// Result channel rsp_*: zero or one result per event, the next stop floor and
// the travel direction (rsp_going_down). rsp_valid holds with a steady payload
// until a cycle with rsp_stall low takes it.
// Flow: one event at a time. A passed floor, an ignored event or an arrival
// while free needs no scan. A call runs one scan, an arrival at the far target
// two, in the serial scan unit that checks one pending-call bit per cycle
// (once for a new target, once for the next stop).
// A stalled receiver does not block the input side: the next event is taken
// while a result waits; the block holds in its emit step only if a second
// result is ready before the first is taken.
// Reset (synchronous, active high) clears all pending calls, puts the car at
// floor 1 with no target, no direction and the free state, and drops rsp_valid.
module elevator_stop_scheduler #(
   parameter int FLOOR_COUNT = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [4:0] req_floor,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [4:0] rsp_stop_floor,
   output logic       rsp_going_down
);
   import ess_pkg::*;

   localparam int IDX_W = $clog2(FLOOR_COUNT);
   localparam int IX_W  = (IDX_W > FLOOR_W) ? IDX_W : FLOOR_W;
   localparam int CNT_W = $clog2(FLOOR_COUNT + 1);
   localparam int CMP_W = (CNT_W > FLOOR_W) ? CNT_W : FLOOR_W;
   localparam logic [CMP_W-1:0] TOP_FLOOR = CMP_W'(FLOOR_COUNT);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_PICK,
      S_NEAR_START,
      S_NEAR,
      S_EMIT
   } state_type;

   state_type             state_ff;
   logic [FLOOR_COUNT-1:0] pending_ff;
   logic [FLOOR_W-1:0]    cur_ff;
   logic [FLOOR_W-1:0]    target_ff;
   dir_type               dir_ff;
   logic                  busy_ff;

   // Latched event and result staging.
   logic [1:0]            item_op_ff;
   logic [FLOOR_W-1:0]    item_floor_ff;
   logic [FLOOR_W-1:0]    stop_ff;

   logic                  rsp_valid_ff;
   logic [FLOOR_W-1:0]    rsp_stop_ff;
   logic                  rsp_down_ff;

   logic                  scan_start_ff;
   logic                  scan_start_in;
   scan_req_type          scan_req_ff;
   scan_res_type          scan_res;

   logic [IX_W-1:0]       item_wide;
   logic [IDX_W-1:0]      item_idx;
   logic                  floor_ok;
   logic [FLOOR_W-1:0]    first_target;
   logic [FLOOR_W-1:0]    call_target;
   logic                  emit_go;

   always_comb begin
      item_wide = IX_W'(item_floor_ff) - IX_W'(1);
      item_idx  = item_wide[IDX_W-1:0];
      // Drop events whose floor is outside 1..FLOOR_COUNT.
      floor_ok  = (item_floor_ff != '0) && (CMP_W'(item_floor_ff) <= TOP_FLOOR);
      // A call takes the target if none exists, or extends it in the travel
      // direction.
      first_target = (target_ff == '0) ? item_floor_ff : target_ff;
      if ((dir_ff == DIR_UP && item_floor_ff > first_target) ||
          (dir_ff == DIR_DOWN && item_floor_ff < first_target)) begin
         call_target = item_floor_ff;
      end else begin
         call_target = first_target;
      end
      // Launch a scan for the next stop, or for a new target when a busy car
      // arrives at its far target.
      scan_start_in = (state_ff == S_NEAR_START) ||
                      ((state_ff == S_EXEC) && floor_ok && (item_op_ff == OP_ARRIVE) &&
                       busy_ff && (item_floor_ff == target_ff));
      // Load the output register when it is free or being taken.
      emit_go = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);
   end

   ess_scan #(
      .FLOOR_COUNT(FLOOR_COUNT)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start_ff),
      .req     (scan_req_ff),
      .pending (pending_ff),
      .res     (scan_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pending_ff    <= '0;
         cur_ff        <= FLOOR_W'(1);
         target_ff     <= '0;
         dir_ff        <= DIR_STAY;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         scan_start_ff <= 1'b0;
      end else begin
         scan_start_ff <= scan_start_in;
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            // Drop the result once the receiver takes it.
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_op_ff    <= req_op;
                  item_floor_ff <= req_floor;
                  state_ff      <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (floor_ok) begin
                  case (item_op_ff)
                     OP_CALL: begin
                        busy_ff              <= 1'b1;
                        pending_ff[item_idx] <= 1'b1;
                        target_ff            <= call_target;
                        state_ff             <= S_NEAR_START;
                     end
                     OP_ARRIVE: begin
                        // An arrival while free is ignored entirely.
                        if (busy_ff) begin
                           cur_ff               <= item_floor_ff;
                           pending_ff[item_idx] <= 1'b0;
                           if (item_floor_ff == target_ff) begin
                              // Target reached: clear it and search a new one,
                              // top down when going up, bottom up otherwise.
                              target_ff     <= '0;
                              scan_req_ff   <= '{up: (dir_ff != DIR_UP), from_edge: 1'b1,
                                                 start: item_floor_ff};
                              state_ff      <= S_PICK;
                           end else begin
                              state_ff <= S_NEAR_START;
                           end
                        end else begin
                           state_ff <= S_IDLE;
                        end
                     end
                     OP_PASS: begin
                        cur_ff   <= item_floor_ff;
                        state_ff <= S_IDLE;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_PICK: begin
               if (scan_res.done) begin
                  if (scan_res.found) begin
                     target_ff <= scan_res.floor_num;
                  end
                  state_ff <= S_NEAR_START;
               end
            end
            S_NEAR_START: begin
               // Scan from the car toward the target side.
               scan_req_ff   <= '{up: (target_ff > cur_ff), from_edge: 1'b0, start: cur_ff};
               state_ff      <= S_NEAR;
            end
            S_NEAR: begin
               if (scan_res.done) begin
                  if (scan_res.found || item_op_ff == OP_CALL) begin
                     // A call always answers; with no stop found it names itself.
                     stop_ff  <= scan_res.found ? scan_res.floor_num : item_floor_ff;
                     dir_ff   <= (cur_ff > target_ff) ? DIR_DOWN : DIR_UP;
                     state_ff <= S_EMIT;
                  end else begin
                     // Nothing left toward the target: go free, keep the target.
                     busy_ff  <= 1'b0;
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_EMIT: begin
               // Hold until the output register is free or being taken.
               if (emit_go) begin
                  rsp_stop_ff  <= stop_ff;
                  rsp_down_ff  <= (dir_ff == DIR_DOWN);
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_stop_floor = rsp_stop_ff;
   assign rsp_going_down = rsp_down_ff;

   // A scan is launched only on the way into one of the two wait steps.
   `ESS_CHECK(a_scan_start_state, scan_start_ff |-> (state_ff == S_PICK || state_ff == S_NEAR), "scan started outside a scan wait step")
   // The scan unit reports only while the controller waits for it.
   `ESS_CHECK(a_scan_done_waited, scan_res.done |-> (state_ff == S_PICK || state_ff == S_NEAR), "scan result arrived with no scan pending")
   // A new result appears only from the emit step.
   `ESS_CHECK(a_rsp_from_emit, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT), "result raised outside the emit step")
   // The target is either cleared or a real floor.
   `ESS_NEVER(a_target_range, CMP_W'(target_ff) > TOP_FLOOR, "far target beyond the top floor")

endmodule
